// ===== design/bdq_pkg.sv =====
`timescale 1ns / 1ps

package bdq_pkg;

   // Field widths of the request, response and control words.
   localparam int KIND_W  = 2;
   localparam int VALUE_W = 32;
   localparam int CAP_W   = 5;
   localparam int OCC_W   = 5;

   // Capacity limit after reset.
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Operation codes carried by req_kind.
   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_BACK  = 2'd0,
      KIND_PUSH_FRONT = 2'd1,
      KIND_POP_FRONT  = 2'd2,
      KIND_POP_BACK   = 2'd3
   } kind_type;

endpackage

// ===== design/bdq_ram.sv =====
`timescale 1ns / 1ps

module bdq_ram #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]    wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0]    rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bounded_deque_with_overwrite_core.sv =====
`timescale 1ns / 1ps
// A result word is registered and appears in the cycle after its request word is accepted.
// Throughput: one word per cycle; the single response register stalls the request
// side only while it holds a word and rsp_stall is high.
// Reset clears the front pointer, the element count and the response valid, and
// sets the capacity limit to 16. The element storage is not cleared.

module bounded_deque_with_overwrite_core #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   // Request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [bdq_pkg::KIND_W-1:0]  req_kind,
   input  logic [bdq_pkg::VALUE_W-1:0] req_push_value,
   // Response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [bdq_pkg::VALUE_W-1:0] rsp_popped_value,
   output logic                        rsp_popped_valid,
   output logic                        rsp_empty_fault,
   output logic                        rsp_overwrote,
   output logic [bdq_pkg::OCC_W-1:0]   rsp_occupancy,
   // Capacity register
   input  logic                        csr_write_enable,
   input  logic [bdq_pkg::CAP_W-1:0]   csr_write_data
);

   import bdq_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_SUM = (PTR_W + 1)'(DEPTH);
   localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);

   // Ring pointer helpers, all modulo DEPTH.
   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? LAST_SLOT : p - 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] slot_at(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] offset);
      logic [PTR_W:0] sum;
      sum = (PTR_W + 1)'(base) + (PTR_W + 1)'(offset);
      if (sum >= DEPTH_SUM) begin
         sum = sum - DEPTH_SUM;
      end
      return sum[PTR_W-1:0];
   endfunction

   logic [CAP_W-1:0] capacity_ff;
   logic [PTR_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             popped_valid_ff, popped_valid_in;
   logic             empty_fault_ff, empty_fault_in;
   logic             overwrote_ff, overwrote_in;
   logic [OCC_W-1:0] occupancy_ff;

   logic                  accept;
   kind_type              kind;
   logic [CMP_W-1:0]      cap_ext;
   logic [CMP_W-1:0]      eff_cap;
   logic                  full;
   logic [CNT_W-1:0]      count_mid;
   logic                  wr_en;
   logic [PTR_W-1:0]      wr_addr;
   logic [PTR_W-1:0]      rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;

   // Request is held off only while a result waits and the sink stalls.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign kind      = kind_type'(req_kind);

   // Effective capacity: zero counts as one, anything above DEPTH saturates.
   always_comb begin
      cap_ext = CMP_W'(capacity_ff);
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > DEPTH_CMP) begin
         eff_cap = DEPTH_CMP;
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign full = (CMP_W'(count_ff) >= eff_cap) && (count_ff != '0);

   // Pointer, count and flag update for the accepted operation.
   always_comb begin
      front_in        = front_ff;
      count_in        = count_ff;
      count_mid       = count_ff;
      wr_en           = 1'b0;
      wr_addr         = front_ff;
      rd_addr         = front_ff;
      popped_valid_in = 1'b0;
      empty_fault_in  = 1'b0;
      overwrote_in    = 1'b0;
      case (kind)
         KIND_PUSH_BACK: begin
            if (full) begin
               overwrote_in = 1'b1;
               front_in     = ptr_inc(front_ff);
               count_mid    = count_ff - 1'b1;
            end
            wr_en    = accept;
            wr_addr  = slot_at(front_in, count_mid);
            count_in = count_mid + 1'b1;
         end
         KIND_PUSH_FRONT: begin
            if (full) begin
               overwrote_in = 1'b1;
               count_mid    = count_ff - 1'b1;
            end
            front_in = ptr_dec(front_ff);
            wr_en    = accept;
            wr_addr  = front_in;
            count_in = count_mid + 1'b1;
         end
         KIND_POP_FRONT: begin
            if (count_ff == '0) begin
               empty_fault_in = 1'b1;
            end else begin
               rd_addr         = front_ff;
               front_in        = ptr_inc(front_ff);
               count_in        = count_ff - 1'b1;
               popped_valid_in = 1'b1;
            end
         end
         KIND_POP_BACK: begin
            if (count_ff == '0) begin
               empty_fault_in = 1'b1;
            end else begin
               rd_addr         = slot_at(front_ff, count_ff - 1'b1);
               count_in        = count_ff - 1'b1;
               popped_valid_in = 1'b1;
            end
         end
         default: begin
            front_in = front_ff;
         end
      endcase
   end

   // Response valid: set on accept, cleared once the word is taken.
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         if (accept) begin
            front_ff <= front_in;
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (accept) begin
         popped_valid_ff <= popped_valid_in;
         empty_fault_ff  <= empty_fault_in;
         overwrote_ff    <= overwrote_in;
         occupancy_ff    <= OCC_W'(count_in);
      end
   end

   // Element storage; read data lands together with the response flags.
   bdq_ram #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (DATA_WIDTH'(req_push_value)),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = popped_valid_ff ? VALUE_W'(rd_data) : '0;
   assign rsp_popped_valid = popped_valid_ff;
   assign rsp_empty_fault  = empty_fault_ff;
   assign rsp_overwrote    = overwrote_ff;
   assign rsp_occupancy    = occupancy_ff;

endmodule
